/* rtl/lzss_pkg.sv */
// shared types and constants for the lzss ring decompressor
// no dependencies; imported by every module of the block except lzss_ram
`default_nettype none

package lzss_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FILL_W     = RING_AW + 1;
    localparam logic [RING_AW-1:0] RING_START = RING_AW'(4078);
    localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(RING_DEPTH);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;

    localparam logic [7:0]  FLAG_FILL = 8'hFF;
    localparam int          LEN_W     = 4;
    localparam int          LEFT_W    = 5;
    localparam logic [LEFT_W-1:0] MIN_MATCH_M1 = LEFT_W'(2);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_ITEM,
        PH_REF2
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_COPY,
        CMD_CLR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         data;
        logic [RING_AW-1:0] offset;
        logic [LEN_W-1:0]   len;
        logic               eos;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/lzss_ring_decompressor.sv */
// top level of the lzss ring decompressor: parser, command queue, copy engine
// depends on lzss_pkg, lzss_front, lzss_cmd_q, lzss_back
//
// channel  | ports                                  | beat
// ---------+----------------------------------------+------------------------------
// input    | s_comp_byte s_end_of_stream s_valid    | one compressed byte
//          | s_ready                                |
// output   | m_out_byte m_last_of_run m_valid       | one decompressed byte
//          | m_ready                                |
//
// the parser takes one byte per cycle while the two-entry command queue has room
// a literal is one byte in the copy engine, a reference len+3 bytes after a load step;
// the single ring read port and the byte-wide output register set the engine's pace
// the ring is not swept at reset: a fill count marks written entries, others read 0
// synchronous active-low reset; a stalled output holds the copy engine, a full queue
// holds s_ready low
`default_nettype none

module lzss_ring_decompressor
    import lzss_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_comp_byte,
    input  wire logic       s_end_of_stream,
    input  wire logic       s_valid,
    output      logic       s_ready,
    output      logic [7:0] m_out_byte,
    output      logic       m_last_of_run,
    output      logic       m_valid,
    input  wire logic       m_ready
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    lzss_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_comp_byte    (s_comp_byte),
        .s_end_of_stream(s_end_of_stream),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .q_full         (q_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    lzss_cmd_q u_cmd_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (pop),
        .head_cmd(head_cmd),
        .empty   (q_empty)
    );

    lzss_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_cmd     (head_cmd),
        .q_empty      (q_empty),
        .pop          (pop),
        .m_out_byte   (m_out_byte),
        .m_last_of_run(m_last_of_run),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_empty))
        else $error("command queue underflow");

    a_push_needs_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_valid && s_ready))
        else $error("command issued without an input beat");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

/* rtl/lzss_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/lzss_cmd_q.sv */
// two-entry command queue between the parser and the copy engine
// depends on lzss_pkg
`default_nettype none

module lzss_cmd_q
    import lzss_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output      logic full,
    input  wire logic pop,
    output      cmd_t head_cmd,
    output      logic empty
);

    cmd_t               slot_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wptr_reg, wptr_next;
    logic [CMDQ_AW-1:0] rptr_reg, rptr_next;
    logic [CMDQ_AW:0]   count_reg, count_next;

    assign full     = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (CMDQ_AW+1)'(push) - (CMDQ_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/lzss_front.sv */
// byte parser: tracks flag bits and reference halves, issues commands
// depends on lzss_pkg
`default_nettype none

module lzss_front
    import lzss_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_comp_byte,
    input  wire logic       s_end_of_stream,
    input  wire logic       s_valid,
    output      logic       s_ready,
    input  wire logic       q_full,
    output      logic       push,
    output      cmd_t       push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [15:0] ctrl_reg, ctrl_next;
    logic [7:0]  off_lo_reg, off_lo_next;
    logic        accept;
    logic [15:0] ctrl_shift;

    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign ctrl_shift = ctrl_reg >> 1;

    // next state
    always_comb begin
        phase_next  = phase_reg;
        ctrl_next   = ctrl_reg;
        off_lo_next = off_lo_reg;
        if (accept) begin
            case (phase_reg)
                PH_ITEM: begin
                    if (ctrl_reg[0]) begin
                        ctrl_next  = ctrl_shift;
                        phase_next = ctrl_shift[8] ? PH_ITEM : PH_FLAG;
                    end else begin
                        off_lo_next = s_comp_byte;
                        phase_next  = PH_REF2;
                    end
                end
                PH_REF2: begin
                    ctrl_next  = ctrl_shift;
                    phase_next = ctrl_shift[8] ? PH_ITEM : PH_FLAG;
                end
                default: begin
                    ctrl_next  = {FLAG_FILL, s_comp_byte};
                    phase_next = PH_ITEM;
                end
            endcase
            if (s_end_of_stream) begin
                phase_next  = PH_FLAG;
                ctrl_next   = '0;
                off_lo_next = '0;
            end
        end
    end

    // outputs
    always_comb begin
        push            = 1'b0;
        push_cmd.kind   = CMD_CLR;
        push_cmd.data   = s_comp_byte;
        push_cmd.offset = {s_comp_byte[7:4], off_lo_reg};
        push_cmd.len    = s_comp_byte[3:0];
        push_cmd.eos    = s_end_of_stream;
        if (accept) begin
            case (phase_reg)
                PH_ITEM: begin
                    if (ctrl_reg[0]) begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_LIT;
                    end else begin
                        push = s_end_of_stream;
                    end
                end
                PH_REF2: begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_COPY;
                end
                default: begin
                    push = s_end_of_stream;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FLAG;
            ctrl_reg   <= '0;
            off_lo_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            ctrl_reg   <= ctrl_next;
            off_lo_reg <= off_lo_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lzss_back.sv */
// copy engine: literal writes, ring copies with forwarding, output register
// depends on lzss_pkg and lzss_ram
`default_nettype none

module lzss_back
    import lzss_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cmd_t       head_cmd,
    input  wire logic       q_empty,
    output      logic       pop,
    output      logic [7:0] m_out_byte,
    output      logic       m_last_of_run,
    output      logic       m_valid,
    input  wire logic       m_ready
);

    logic               seq_active_reg, seq_active_next;
    logic [RING_AW-1:0] seq_addr_reg, seq_addr_next;
    logic [LEFT_W-1:0]  seq_left_reg, seq_left_next;
    logic               seq_eos_reg, seq_eos_next;

    logic               cur_valid_reg, cur_valid_next;
    cmd_kind_t          cur_kind_reg, cur_kind_next;
    logic [7:0]         cur_lit_reg, cur_lit_next;
    logic               cur_last_reg, cur_last_next;
    logic               cur_eos_reg, cur_eos_next;
    logic               cur_fwd_reg, cur_fwd_next;
    logic               cur_hit_reg, cur_hit_next;

    logic [RING_AW-1:0] wp_reg, wp_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [7:0]         wr_byte_reg;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_byte_reg;
    logic               m_last_reg;

    logic               adv;
    logic               do_write;
    logic               do_reset;
    logic               issue;
    logic [7:0]         cur_byte;
    logic [7:0]         ram_q;
    logic [RING_AW-1:0] rel_addr;

    assign adv      = !m_valid_reg || m_ready;
    assign do_write = adv && cur_valid_reg && (cur_kind_reg != CMD_CLR);
    assign do_reset = adv && cur_valid_reg && cur_eos_reg && cur_last_reg;
    assign issue    = adv && seq_active_reg;
    assign pop      = adv && !seq_active_reg && !q_empty;
    assign rel_addr = seq_addr_reg - RING_START;

    always_comb begin
        if (cur_kind_reg == CMD_LIT) begin
            cur_byte = cur_lit_reg;
        end else if (cur_fwd_reg) begin
            cur_byte = wr_byte_reg;
        end else if (cur_hit_reg) begin
            cur_byte = ram_q;
        end else begin
            cur_byte = '0;
        end
    end

    always_comb begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (do_reset) begin
            wp_next   = RING_START;
            fill_next = '0;
        end else if (do_write) begin
            wp_next = wp_reg + 1'b1;
            if (fill_reg != FILL_FULL) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb begin
        seq_active_next = seq_active_reg;
        seq_addr_next   = seq_addr_reg;
        seq_left_next   = seq_left_reg;
        seq_eos_next    = seq_eos_reg;
        cur_valid_next  = cur_valid_reg;
        cur_kind_next   = cur_kind_reg;
        cur_lit_next    = cur_lit_reg;
        cur_last_next   = cur_last_reg;
        cur_eos_next    = cur_eos_reg;
        cur_fwd_next    = cur_fwd_reg;
        cur_hit_next    = cur_hit_reg;
        if (adv) begin
            cur_valid_next = 1'b0;
            if (seq_active_reg) begin
                cur_valid_next  = 1'b1;
                cur_kind_next   = CMD_COPY;
                cur_last_next   = (seq_left_reg == '0);
                cur_eos_next    = seq_eos_reg;
                cur_fwd_next    = do_write && !do_reset && (seq_addr_reg == wp_reg);
                cur_hit_next    = ({1'b0, rel_addr} < fill_next);
                seq_addr_next   = seq_addr_reg + 1'b1;
                seq_left_next   = seq_left_reg - 1'b1;
                seq_active_next = (seq_left_reg != '0);
            end else if (pop) begin
                case (head_cmd.kind)
                    CMD_COPY: begin
                        seq_active_next = 1'b1;
                        seq_addr_next   = head_cmd.offset;
                        seq_left_next   = LEFT_W'(head_cmd.len) + MIN_MATCH_M1;
                        seq_eos_next    = head_cmd.eos;
                    end
                    CMD_LIT: begin
                        cur_valid_next = 1'b1;
                        cur_kind_next  = CMD_LIT;
                        cur_lit_next   = head_cmd.data;
                        cur_last_next  = 1'b1;
                        cur_eos_next   = head_cmd.eos;
                        cur_fwd_next   = 1'b0;
                        cur_hit_next   = 1'b0;
                    end
                    default: begin
                        cur_valid_next = 1'b1;
                        cur_kind_next  = CMD_CLR;
                        cur_last_next  = 1'b1;
                        cur_eos_next   = 1'b1;
                        cur_fwd_next   = 1'b0;
                        cur_hit_next   = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = do_write;
        end
    end

    lzss_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (do_write),
        .waddr(wp_reg),
        .wdata(cur_byte),
        .re   (issue),
        .raddr(seq_addr_reg),
        .rdata(ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_active_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
            wp_reg         <= RING_START;
            fill_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            seq_active_reg <= seq_active_next;
            cur_valid_reg  <= cur_valid_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_addr_reg <= seq_addr_next;
        seq_left_reg <= seq_left_next;
        seq_eos_reg  <= seq_eos_next;
        cur_kind_reg <= cur_kind_next;
        cur_lit_reg  <= cur_lit_next;
        cur_last_reg <= cur_last_next;
        cur_eos_reg  <= cur_eos_next;
        cur_fwd_reg  <= cur_fwd_next;
        cur_hit_reg  <= cur_hit_next;
        if (do_write) begin
            wr_byte_reg <= cur_byte;
            m_byte_reg  <= cur_byte;
            m_last_reg  <= cur_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_last_of_run = m_last_reg;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for lzss_ring_decompressor: directed table, then random streams
// predicts every output beat with its own ring decoder; depends on rtl/lzss_pkg.sv and the rtl
`default_nettype none

module tb_top;
    import lzss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int MIN_MATCH    = 3;
    localparam int IDLE_PCT     = 22;
    localparam int RANDOM_BEATS = 140;
    localparam int CALM_FIRST   = 60;
    localparam int CALM_LAST    = 110;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_MAX   = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS     = 23;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] code;
        logic       eos;
        logic       has_lit;
        logic [7:0] lit;
    } dir_row_t;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic [7:0] s_comp_byte     = 8'h00;
    logic       s_end_of_stream = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;
    logic       m_valid;
    logic       m_ready         = 1'b0;

    // decoder state mirrored from the stream
    logic [7:0]  hist_ring [RING_DEPTH];
    logic [11:0] wr_pos;
    logic [15:0] ctl_bits;
    phase_t      dec_phase;
    logic [7:0]  ref_lo;

    out_beat_t   expected_out [$];
    out_beat_t   head;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_idle_pct = IDLE_PCT;
    int unsigned rx_idle_pct = IDLE_PCT;
    logic        hold_go     = 1'b0;
    logic        rx_hold     = 1'b0;
    logic [7:0]  planned_hi  = 8'h00;

    // flag 0x03: two literals then references; later rows end streams at each phase
    dir_row_t dir_rows [DIR_ROWS] = '{
        {8'h03, 1'b0, 1'b0, 8'h00},
        {8'h00, 1'b0, 1'b1, 8'h00},
        {8'hFF, 1'b0, 1'b1, 8'hFF},
        {8'hEE, 1'b0, 1'b0, 8'h00},
        {8'hFF, 1'b0, 1'b0, 8'h00},
        {8'h00, 1'b0, 1'b0, 8'h00},
        {8'h00, 1'b0, 1'b0, 8'h00},
        {8'h34, 1'b0, 1'b0, 8'h00},
        {8'h5C, 1'b1, 1'b0, 8'h00},
        {8'hAA, 1'b1, 1'b0, 8'h00},
        {8'h55, 1'b0, 1'b0, 8'h00},
        {8'h5A, 1'b0, 1'b1, 8'h5A},
        {8'hA5, 1'b1, 1'b0, 8'h00},
        {8'hFF, 1'b0, 1'b0, 8'h00},
        {8'h80, 1'b0, 1'b1, 8'h80},
        {8'h01, 1'b1, 1'b1, 8'h01},
        {8'h00, 1'b0, 1'b0, 8'h00},
        {8'hFF, 1'b0, 1'b0, 8'h00},
        {8'hF0, 1'b0, 1'b0, 8'h00},
        {8'hED, 1'b0, 1'b0, 8'h00},
        {8'hF2, 1'b0, 1'b0, 8'h00},
        {8'h01, 1'b0, 1'b0, 8'h00},
        {8'h0F, 1'b0, 1'b0, 8'h00}
    };

    lzss_ring_decompressor u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_comp_byte     (s_comp_byte),
        .s_end_of_stream (s_end_of_stream),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_run   (m_last_of_run),
        .m_valid         (m_valid),
        .m_ready         (m_ready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void clear_history();
        for (int k = 0; k < RING_DEPTH; k++) begin
            hist_ring[k] = 8'h00;
        end
        wr_pos      = RING_START;
        ctl_bits    = 16'h0000;
        dec_phase   = PH_FLAG;
        ref_lo      = 8'h00;
    endfunction

    function automatic void store_byte(input logic [7:0] b, input logic last);
        out_beat_t ob;
        hist_ring[wr_pos] = b;
        wr_pos            = wr_pos + 12'd1;
        ob.data = b;
        ob.last = last;
        expected_out.push_back(ob);
    endfunction

    function automatic void next_slot();
        ctl_bits  = ctl_bits >> 1;
        dec_phase = ctl_bits[8] ? PH_ITEM : PH_FLAG;
    endfunction

    // decode one accepted byte, queueing the output beats it produces
    function automatic void decode_beat(input logic [7:0] b, input logic eos);
        logic [11:0] src;
        int unsigned cnt;
        case (dec_phase)
            PH_ITEM: begin
                if (ctl_bits[0]) begin
                    store_byte(b, 1'b1);
                    next_slot();
                end else begin
                    ref_lo    = b;
                    dec_phase = PH_REF2;
                end
            end
            PH_REF2: begin
                src = {b[7:4], ref_lo};
                cnt = int'(b[3:0]) + MIN_MATCH;
                for (int unsigned i = 0; i < cnt; i++) begin
                    store_byte(hist_ring[src + 12'(i)], i + 1 == cnt);
                end
                next_slot();
            end
            default: begin
                ctl_bits  = {FLAG_FILL, b};
                dec_phase = PH_ITEM;
            end
        endcase
        if (eos) clear_history();
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(input logic [7:0] b, input logic eos, input logic has_lit,
                             input logic [7:0] lit);
        out_beat_t ob;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_comp_byte     <= b;
        s_end_of_stream <= eos;
        s_valid         <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_beat(b, eos);
        if (has_lit) begin
            ob.data = lit;
            ob.last = 1'b1;
            expected_out[expected_out.size() - 1] = ob;
        end
        @(negedge aclk);
    endtask

    // pick the next byte from where the decoder stands so streams stay well formed
    task automatic gen_beat(output logic [7:0] b, output logic eos);
        logic [11:0] ofs;
        logic [3:0]  len;
        int unsigned pick;
        eos = ($urandom_range(99) < 2);
        b   = 8'($urandom);
        pick = $urandom_range(99);
        if (dec_phase == PH_REF2) begin
            if (pick >= 10) b = planned_hi;
        end else if (dec_phase == PH_ITEM && !ctl_bits[0]) begin
            if (pick < 50)      ofs = wr_pos - 12'($urandom_range(64, 1));
            else if (pick < 70) ofs = wr_pos - 12'($urandom_range(3, 1));
            else if (pick < 85) ofs = 12'($urandom);
            else                ofs = wr_pos + 12'($urandom_range(30, 0));
            len        = 4'($urandom_range(15, 0));
            b          = ofs[7:0];
            planned_hi = {ofs[11:8], len};
        end
    endtask

    initial begin : rx_hold_off
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected output beat: data %h last %b", m_out_byte,
                             m_last_of_run);
                mismatches++;
            end else begin
                head = expected_out.pop_front();
                if (m_out_byte !== head.data || m_last_of_run !== head.last) begin
                    if (mismatches < REPORT_MAX)
                        $display("output mismatch: expected data %h last %b, got data %h last %b",
                                 head.data, head.last, m_out_byte, m_last_of_run);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] b;
        logic       eos;
        clear_history();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_beat(dir_rows[r].code, dir_rows[r].eos, dir_rows[r].has_lit, dir_rows[r].lit);
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == CALM_FIRST) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_go     = 1'b1;
            end else if (n == CALM_LAST) begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            gen_beat(b, eos);
            send_beat(b, eos, 1'b0, 8'h00);
        end

        for (int n = 0; n < 20; n++) begin
            gen_beat(b, eos);
            send_beat(b, 1'b0, 1'b0, 8'h00);
        end
        gen_beat(b, eos);
        send_beat(b, 1'b1, 1'b0, 8'h00);
        s_valid <= 1'b0;

        while (expected_out.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/lzss_pkg.sv
rtl/lzss_ram.sv
rtl/lzss_cmd_q.sv
rtl/lzss_front.sv
rtl/lzss_back.sv
rtl/lzss_ring_decompressor.sv
sim/tb_top.sv
